[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define CPCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define CPCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

[design/cpcc_pkg.sv]
// Package for the cluster pair co-occurrence counter.
// Holds sizes, request and result types, codes and helper functions; no dependencies.
package cpcc_pkg;
  localparam int AXES         = 4;
  localparam int MAX_CLUSTERS = 16;
  localparam int CL_W         = $clog2(MAX_CLUSTERS);
  localparam int NUM_W        = CL_W + 1;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int EDGES        = AXES - 1;
  localparam int BANK_AW      = 2 * CL_W;
  localparam int BANK_DEPTH   = 1 << BANK_AW;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_AXIS_COUNT = 3'd0,
    REG_AXIS_ORDER = 3'd1,
    REG_CLUSTERS0  = 3'd2,
    REG_CLUSTERS1  = 3'd3,
    REG_CLUSTERS2  = 3'd4,
    REG_CLUSTERS3  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN,
    S_RD,
    S_UPD,
    S_LOOK,
    S_LOOK_DATA,
    S_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                       operation;
    logic [1:0]                axis;
    logic [3:0]                cluster_a;
    logic [3:0]                cluster_b;
    logic signed [15:0]        boundary;
    logic signed [15:0]        sample_0;
    logic signed [15:0]        sample_1;
    logic signed [15:0]        sample_2;
    logic signed [15:0]        sample_3;
  } request_t;

  typedef struct packed {
    logic [31:0] edge_count;
    logic        status;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
  } edge_req_t;

  typedef logic [AXES-1:0][CL_W-1:0] cls_vec_t;

  function automatic logic [NUM_W-1:0] clamp_clusters(input logic [4:0] raw);
    logic [NUM_W-1:0] n;
    n = raw;
    if (raw == 5'd0) n = NUM_W'(1);
    else if (raw > 5'(MAX_CLUSTERS)) n = NUM_W'(MAX_CLUSTERS);
    return n;
  endfunction

  function automatic logic [2:0] active_axes(input logic [2:0] raw);
    logic [2:0] a;
    a = raw;
    if (raw < 3'd2) a = 3'd2;
    else if (raw > 3'(AXES)) a = 3'(AXES);
    return a;
  endfunction
endpackage

[design/cpcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/cpcc_bin_lane.sv]
// One binning lane: boundary registers of one component and a comparator row.
// Depends on cpcc_pkg.
module cpcc_bin_lane (
  input  logic                                  clk,
  input  logic                                  load_en,
  input  logic [cpcc_pkg::CL_W-1:0]             load_idx,
  input  logic signed [cpcc_pkg::SAMPLE_WIDTH-1:0] load_val,
  input  logic signed [cpcc_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic [cpcc_pkg::NUM_W-1:0]            num,
  input  logic                                  capture,
  output logic [cpcc_pkg::CL_W-1:0]             cls
);
  logic signed [cpcc_pkg::SAMPLE_WIDTH-1:0] bnd [cpcc_pkg::MAX_CLUSTERS];
  logic [cpcc_pkg::MAX_CLUSTERS-1:0] hit;
  logic [cpcc_pkg::CL_W-1:0]         pick;
  logic [cpcc_pkg::CL_W-1:0]         cls_next;

  always_ff @(posedge clk) begin
    if (load_en) begin
      bnd[load_idx] <= load_val;
    end
  end

  always_comb begin
    pick = '0;
    for (int k = 0; k < cpcc_pkg::MAX_CLUSTERS; k++) begin
      hit[k] = (cpcc_pkg::NUM_W'(k) < num) && (sample <= bnd[k]);
    end
    for (int k = cpcc_pkg::MAX_CLUSTERS - 1; k >= 0; k--) begin
      if (hit[k]) pick = cpcc_pkg::CL_W'(k);
    end
    cls_next = (|hit) ? pick : cpcc_pkg::CL_W'(num - cpcc_pkg::NUM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      cls <= cls_next;
    end
  end
endmodule

[design/cpcc_merge.sv]
// Merge stage: pairs lane cluster indices along the axis order into bank requests.
// Depends on cpcc_pkg.
module cpcc_merge (
  input  cpcc_pkg::cls_vec_t   cls,
  input  logic [7:0]           axis_order,
  input  logic [2:0]           n_active,
  output cpcc_pkg::edge_req_t  ereq [cpcc_pkg::EDGES]
);
  always_comb begin
    for (int p = 0; p < cpcc_pkg::EDGES; p++) begin
      ereq[p].en   = 3'(p + 1) < n_active;
      ereq[p].addr = {cls[axis_order[2*p +: 2]], cls[axis_order[2*(p+1) +: 2]]};
    end
  end
endmodule

[design/cluster_pair_cooccurrence_counter.sv]
// Top level of the cluster pair co-occurrence counter.
// Depends on cpcc_pkg, cpcc_bin_lane, cpcc_merge, cpcc_ram and assert_macros.svh.
//
//   port set       direction  handshake
//   req            in         start && !busy
//   rsp            out        done, one cycle, no stall
//   cfg_*          in         cfg_we, no wait
//
// Voxel count: accept, bin, bank read, bank write, result, set by the read-modify-write on
// the per-edge count banks; busy is high until the result, so one request at a time.
// Read: lookup, result. Load: boundary write, result. Clear: one bank row per cycle.
// After reset all 256 rows are cleared with busy high. The result cannot be stalled.
`include "assert_macros.svh"
module cluster_pair_cooccurrence_counter (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cpcc_pkg::request_t  req,
  output logic                done,
  output cpcc_pkg::result_t   rsp,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  cpcc_pkg::state_t   state, state_next;
  cpcc_pkg::request_t req_q;
  logic               sweep_ack;
  logic [cpcc_pkg::BANK_AW-1:0] sweep;

  logic [2:0] axis_count;
  logic [7:0] axis_order;
  logic [4:0] clusters [cpcc_pkg::AXES];
  logic [cpcc_pkg::NUM_W-1:0] num [cpcc_pkg::AXES];
  logic [2:0] n_active;

  logic accept;
  logic capture;
  logic signed [cpcc_pkg::SAMPLE_WIDTH-1:0] samples [cpcc_pkg::AXES];
  cpcc_pkg::cls_vec_t  cls;
  cpcc_pkg::edge_req_t ereq [cpcc_pkg::EDGES];

  logic                                 bank_we    [cpcc_pkg::EDGES];
  logic [cpcc_pkg::BANK_AW-1:0]         bank_waddr [cpcc_pkg::EDGES];
  logic [cpcc_pkg::COUNT_WIDTH-1:0]     bank_wdata [cpcc_pkg::EDGES];
  logic [cpcc_pkg::BANK_AW-1:0]         bank_raddr [cpcc_pkg::EDGES];
  logic [cpcc_pkg::COUNT_WIDTH-1:0]     bank_rdata [cpcc_pkg::EDGES];

  logic                                 rd_bad;
  logic [1:0]                           o1, o2;
  logic [cpcc_pkg::COUNT_WIDTH-1:0]     rd_sel;

  assign accept = start && !busy;
  assign n_active = cpcc_pkg::active_axes(axis_count);
  assign samples[0] = req_q.sample_0;
  assign samples[1] = req_q.sample_1;
  assign samples[2] = req_q.sample_2;
  assign samples[3] = req_q.sample_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count <= 3'd4;
      axis_order <= 8'd228;
      for (int c = 0; c < cpcc_pkg::AXES; c++) clusters[c] <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpcc_pkg::REG_AXIS_COUNT: axis_count  <= cfg_data[2:0];
        cpcc_pkg::REG_AXIS_ORDER: axis_order  <= cfg_data;
        cpcc_pkg::REG_CLUSTERS0:  clusters[0] <= cfg_data[4:0];
        cpcc_pkg::REG_CLUSTERS1:  clusters[1] <= cfg_data[4:0];
        cpcc_pkg::REG_CLUSTERS2:  clusters[2] <= cfg_data[4:0];
        cpcc_pkg::REG_CLUSTERS3:  clusters[3] <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < cpcc_pkg::AXES; c++) num[c] = cpcc_pkg::clamp_clusters(clusters[c]);
  end

  for (genvar g = 0; g < cpcc_pkg::AXES; g++) begin : g_lane
    cpcc_bin_lane u_lane (
      .clk      (clk),
      .load_en  (accept && req.operation == cpcc_pkg::OP_LOAD && req.axis == 2'(g)),
      .load_idx (req.cluster_a),
      .load_val (req.boundary),
      .sample   (samples[g]),
      .num      (num[g]),
      .capture  (capture),
      .cls      (cls[g])
    );
  end

  cpcc_merge u_merge (
    .cls        (cls),
    .axis_order (axis_order),
    .n_active   (n_active),
    .ereq       (ereq)
  );

  for (genvar e = 0; e < cpcc_pkg::EDGES; e++) begin : g_bank
    cpcc_ram #(
      .WIDTH (cpcc_pkg::COUNT_WIDTH),
      .DEPTH (cpcc_pkg::BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[e]),
      .waddr (bank_waddr[e]),
      .wdata (bank_wdata[e]),
      .raddr (bank_raddr[e]),
      .rdata (bank_rdata[e])
    );
  end

  always_comb begin
    o1 = axis_order[2*req_q.axis +: 2];
    o2 = axis_order[2*(2'(req_q.axis + 2'd1)) +: 2];
    rd_bad = (3'(req_q.axis) + 3'd1 >= n_active)
          || ({1'b0, req_q.cluster_a} >= num[o1])
          || ({1'b0, req_q.cluster_b} >= num[o2]);
    rd_sel = '0;
    for (int e = 0; e < cpcc_pkg::EDGES; e++) begin
      if (req_q.axis == 2'(e)) rd_sel = bank_rdata[e];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cpcc_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            cpcc_pkg::OP_COUNT: state_next = cpcc_pkg::S_BIN;
            cpcc_pkg::OP_LOAD:  state_next = cpcc_pkg::S_DONE;
            cpcc_pkg::OP_READ:  state_next = cpcc_pkg::S_LOOK;
            cpcc_pkg::OP_CLEAR: state_next = cpcc_pkg::S_CLR;
            default:            state_next = cpcc_pkg::S_IDLE;
          endcase
        end
      end
      cpcc_pkg::S_BIN:       state_next = cpcc_pkg::S_RD;
      cpcc_pkg::S_RD:        state_next = cpcc_pkg::S_UPD;
      cpcc_pkg::S_UPD:       state_next = cpcc_pkg::S_DONE;
      cpcc_pkg::S_LOOK:      state_next = cpcc_pkg::S_LOOK_DATA;
      cpcc_pkg::S_LOOK_DATA: state_next = cpcc_pkg::S_DONE;
      cpcc_pkg::S_CLR: begin
        if (sweep == '1) state_next = sweep_ack ? cpcc_pkg::S_DONE : cpcc_pkg::S_IDLE;
      end
      cpcc_pkg::S_DONE:      state_next = cpcc_pkg::S_IDLE;
      default:               state_next = cpcc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy    = state != cpcc_pkg::S_IDLE;
    done    = state == cpcc_pkg::S_DONE;
    capture = state == cpcc_pkg::S_BIN;
    for (int e = 0; e < cpcc_pkg::EDGES; e++) begin
      bank_we[e]    = 1'b0;
      bank_waddr[e] = ereq[e].addr;
      bank_wdata[e] = (bank_rdata[e] == '1) ? bank_rdata[e]
                                            : bank_rdata[e] + cpcc_pkg::COUNT_WIDTH'(1);
      bank_raddr[e] = ereq[e].addr;
      unique case (state)
        cpcc_pkg::S_UPD: bank_we[e] = ereq[e].en;
        cpcc_pkg::S_LOOK: bank_raddr[e] = {req_q.cluster_a, req_q.cluster_b};
        cpcc_pkg::S_CLR: begin
          bank_we[e]    = 1'b1;
          bank_waddr[e] = sweep;
          bank_wdata[e] = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpcc_pkg::S_CLR;
      sweep     <= '0;
      sweep_ack <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cpcc_pkg::S_CLR) sweep <= sweep + 1'b1;
      if (accept) sweep_ack <= req.operation == cpcc_pkg::OP_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q          <= req;
      rsp.edge_count <= '0;
      rsp.status     <= 1'b0;
    end else if (state == cpcc_pkg::S_LOOK_DATA) begin
      rsp.edge_count <= rd_bad ? '0 : rd_sel;
      rsp.status     <= rd_bad;
    end
  end

  `CPCC_ASSERT_NOW(a_done_busy, done, busy)
  `CPCC_ASSERT_NOW(a_err_zero, done && rsp.status, rsp.edge_count == '0)
  `CPCC_ASSERT_NEXT(a_accept_busy, accept, busy)
  `CPCC_ASSERT_NOW(a_write_idle, bank_we[0], state == cpcc_pkg::S_UPD || state == cpcc_pkg::S_CLR)
endmodule
